[hw/rtl/assert_macros.svh]
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/s121_pkg.sv]
`default_nettype none

package s121_pkg;

    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = SAMPLE_W + 3;   // holds the 1-2-1 and 4x sums
    localparam int NUM_TAPS = 2;              // newer and older sample cells
    localparam int QDEPTH   = 4;              // result queue entries
    localparam int QAW      = $clog2(QDEPTH);
    localparam int QCW      = QAW + 1;

    localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(127);
    localparam logic signed [SUM_W-1:0] SAT_LOW  = -SUM_W'(128);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;

    typedef struct packed {
        t_sample smoothed;
        logic    final_result;
    } t_result;

    // up to two results enter the queue per accepted sample
    typedef struct packed {
        logic    v0;
        t_result d0;
        logic    v1;
        t_result d1;
    } t_push;

    typedef struct packed {
        logic           room;   // at least two free entries
        logic [QCW-1:0] count;
    } t_qstat;

    function automatic t_sample sat8(input t_sum s);
        t_sum r;
        r = s;
        if (s > SAT_HIGH) r = SAT_HIGH;
        if (s < SAT_LOW) r = SAT_LOW;
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/smooth_121_int8_saturating.sv]
`default_nettype none

// 1-2-1 smoothing of signed 8-bit samples with saturation to -128..127.
// Each sample arrives on the slave stream with tlast marking the end of its
// sequence; for every sample the block emits prev + 2*cur + next, with the
// edge sample repeated at both ends, so a one-sample sequence gives 4*x.
// The result for a sample appears once its successor (or tlast) is seen.
// Rate: one sample transaction per clock while s_axis_tready is high. A sample
// produces zero, one or two results (two for the last sample of a sequence
// longer than one); results leave at one per clock while m_axis_tready is high,
// via a four-entry queue, and s_axis_tready is high while it has at least
// two free entries. A result is valid on the master stream the cycle after its
// transaction at best. The held samples live in a chain of two cells, newer
// then older, that shift on each accepted sample; an opening sample fills both.
`include "assert_macros.svh"

module smooth_121_int8_saturating
    import s121_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] sample
    input  wire logic       s_axis_tlast,   // final_sample
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] smoothed
    output logic            m_axis_tlast    // final_result
);

    logic    r_open;      // a sample is held and its result pending
    logic    n_open;
    logic    w_acc;
    t_sample w_x;
    t_sample w_tap [NUM_TAPS];
    t_sum    w_xs;
    t_sum    w_new;
    t_sum    w_old;
    t_sum    w_sum_mid;   // older + 2*newer + x
    t_sum    w_sum_end;   // newer + 3*x, last result of a sequence
    t_sum    w_sum_one;   // 4*x, one-sample sequence
    t_push   w_push;
    t_result w_head;
    t_qstat  w_stat;

    assign w_x   = $signed(s_axis_tdata);
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // sample cells: tap 0 holds the newer sample, tap 1 the older one
    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
        t_sample w_chain;
        if (k == 0) begin : g_head
            assign w_chain = w_x;
        end else begin : g_body
            assign w_chain = w_tap[k-1];
        end
        s121_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_acc),
            .i_restart (!r_open),
            .i_fresh   (w_x),
            .i_chain   (w_chain),
            .o_tap     (w_tap[k])
        );
    end

    // three-tap sums, sign extended to the sum width
    assign w_xs      = SUM_W'(w_x);
    assign w_new     = SUM_W'(w_tap[0]);
    assign w_old     = SUM_W'(w_tap[NUM_TAPS-1]);
    assign w_sum_mid = w_old + w_new + w_new + w_xs;
    assign w_sum_end = w_new + w_xs + w_xs + w_xs;
    assign w_sum_one = w_xs <<< 2;

    always_comb begin
        w_push.v0              = w_acc && (r_open || s_axis_tlast);
        w_push.d0.smoothed     = r_open ? sat8(w_sum_mid) : sat8(w_sum_one);
        w_push.d0.final_result = !r_open;
        w_push.v1              = w_acc && r_open && s_axis_tlast;
        w_push.d1.smoothed     = sat8(w_sum_end);
        w_push.d1.final_result = 1'b1;
    end

    // every accepted sample leaves the sequence open unless it is the last
    always_comb begin
        n_open = r_open;
        if (w_acc) begin
            n_open = !s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else begin
            r_open <= n_open;
        end
    end

    s121_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    assign s_axis_tready = w_stat.room;
    assign m_axis_tdata  = w_head.smoothed;
    assign m_axis_tlast  = w_head.final_result;

    // queue never holds more than its depth
    `ASSERT_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, w_stat.count <= QCW'(QDEPTH))
    // a last sample always closes the sequence
    `ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, w_acc && s_axis_tlast, !r_open)
    // any result push is followed by a valid result
    `ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_push.v0, m_axis_tvalid)
    // a second result only with a first one
    `ASSERT_IMPL(a_pair, i_clk, i_rst_n, w_push.v1, w_push.v0)

endmodule

`default_nettype wire

[hw/rtl/s121_cell.sv]
`default_nettype none

module s121_cell
    import s121_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_shift,     // a sample transaction is taken
    input  wire logic    i_restart,   // no sequence open: load the fresh sample
    input  wire t_sample i_fresh,
    input  wire t_sample i_chain,     // neighbor on the input side
    output t_sample      o_tap
);

    t_sample r_tap;
    t_sample n_tap;

    always_comb begin
        n_tap = r_tap;
        if (i_shift) begin
            n_tap = i_restart ? i_fresh : i_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else begin
            r_tap <= n_tap;
        end
    end

    assign o_tap = r_tap;

endmodule

`default_nettype wire

[hw/rtl/s121_outq.sv]
`default_nettype none

module s121_outq
    import s121_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_result      o_head,
    output t_qstat       o_stat
);

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic [QAW-1:0] n_wr;
    logic [QAW-1:0] n_rd;
    logic [QCW-1:0] n_count;
    logic           w_pop;
    logic [QAW-1:0] w_wr1;

    assign w_pop = i_pop && (r_count != '0);
    assign w_wr1 = r_wr + QAW'(1);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.v0) begin
            n_wr    = n_wr + QAW'(1);
            n_count = n_count + QCW'(1);
        end
        if (i_push.v1) begin
            n_wr    = n_wr + QAW'(1);
            n_count = n_count + QCW'(1);
        end
        if (w_pop) begin
            n_rd    = r_rd + QAW'(1);
            n_count = n_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // payload entries, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (i_push.v0 && (r_wr == QAW'(i))) begin
                r_mem[i] <= i_push.d0;
            end else if (i_push.v1 && (w_wr1 == QAW'(i))) begin
                r_mem[i] <= i_push.d1;
            end
        end
    end

    assign o_valid      = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.room  = (r_count <= QCW'(QDEPTH - 2));

endmodule

`default_nettype wire

[tb/smooth_121_check.sv]
`timescale 1ns / 100ps

module smooth_121_check
    import s121_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_in_data,    // [7:0] sample
    input  wire logic       i_in_last,    // final_sample
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_data,   // [7:0] smoothed
    input  wire logic       i_out_last,   // final_result
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked,
    output int              o_clipped
);

    localparam int SMOOTH_MAX = 127;
    localparam int SMOOTH_MIN = -128;
    localparam int PRINT_CAP  = 40;

    // filter state mirrored from the stream
    t_sample older_tap;
    t_sample newer_tap;
    logic    run_open;

    t_result smoothed_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_clipped    = 0;
        older_tap    = '0;
        newer_tap    = '0;
        run_open     = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < PRINT_CAP)
            $display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    // clip a wide sum to int8 and count how often the limits are hit
    function automatic t_sample clip_int8(input int sum);
        if (sum > SMOOTH_MAX) begin
            o_clipped++;
            return t_sample'(SMOOTH_MAX);
        end
        if (sum < SMOOTH_MIN) begin
            o_clipped++;
            return t_sample'(SMOOTH_MIN);
        end
        return t_sample'(sum);
    endfunction

    task automatic push_smoothed(input int sum, input logic is_end);
        t_result r;
        r.smoothed     = clip_int8(sum);
        r.final_result = is_end;
        smoothed_q.push_back(r);
    endtask

    task automatic predict_sample(input t_sample x, input logic is_end);
        int older_v;
        int newer_v;
        int x_v;
        x_v = int'(x);
        if (!run_open) begin
            older_tap = x;
            newer_tap = x;
            if (is_end)
                push_smoothed(4 * x_v, 1'b1);
            else
                run_open = 1'b1;
        end else begin
            older_v = int'(older_tap);
            newer_v = int'(newer_tap);
            push_smoothed(older_v + 2 * newer_v + x_v, 1'b0);
            older_tap = newer_tap;
            newer_tap = x;
            if (is_end) begin
                // right edge: the last sample stands in for its missing successor
                push_smoothed(int'(older_tap) + 3 * int'(newer_tap), 1'b1);
                run_open = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            smoothed_q.delete();
            older_tap = '0;
            newer_tap = '0;
            run_open  = 1'b0;
        end else begin
            // results first: a result never comes from the same-edge sample
            if (i_out_valid && i_out_ready) begin
                if (smoothed_q.size() == 0) begin
                    report_mismatch("unexpected result", int'($signed(i_out_data)), 0);
                end else begin
                    want = smoothed_q.pop_front();
                    if ($signed(i_out_data) != want.smoothed)
                        report_mismatch("smoothed", int'($signed(i_out_data)),
                                        int'(want.smoothed));
                    if (i_out_last != want.final_result)
                        report_mismatch("final_result", int'(i_out_last),
                                        int'(want.final_result));
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready)
                predict_sample(t_sample'(i_in_data), i_in_last);
        end
        o_pending = smoothed_q.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import s121_pkg::*;

    localparam int RUN_ITEMS   = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] sample
    logic       s_axis_tlast = 1'b0;     // final_sample
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] smoothed
    logic       m_axis_tlast;            // final_result

    int fail_count;
    int pending_results;
    int results_checked;
    int clipped_results;

    // idling knobs, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;
    // long receiver hold-off, counted down by the receiver process
    int hold_left = 0;

    int samples_sent = 0;
    int runs_sent    = 0;

    always #5 i_clk = ~i_clk;

    smooth_121_int8_saturating dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    smooth_121_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (results_checked),
        .o_clipped    (clipped_results)
    );

    // result side: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one sample transaction: optional idle gap, then hold until accepted
    task automatic send_sample(input t_sample x, input logic is_end);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tlast  <= is_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        samples_sent++;
    endtask

    // sample flavors: full range, small values that stay unclipped, near the rails
    function automatic t_sample pick_sample(input int flavor);
        int r;
        case (flavor)
            0: begin
                return t_sample'($urandom_range(255));
            end
            1: begin
                return t_sample'(int'($urandom_range(63)) - 32);
            end
            default: begin
                r = $urandom_range(4);
                case (r)
                    0: return t_sample'(127);
                    1: return t_sample'(-128);
                    2: return t_sample'(126);
                    3: return t_sample'(-127);
                    default: return t_sample'($urandom_range(255));
                endcase
            end
        endcase
    endfunction

    // one sequence with random length: mostly short, some long
    task automatic send_random_run();
        int run_len;
        int flavor;
        int r;
        int k;
        r = $urandom_range(99);
        if (r < 55)
            run_len = $urandom_range(4, 1);
        else if (r < 90)
            run_len = $urandom_range(16, 5);
        else
            run_len = $urandom_range(64, 17);
        flavor = $urandom_range(2);
        for (k = 0; k < run_len; k++)
            send_sample(pick_sample(flavor), k == run_len - 1);
        runs_sent++;
    endtask

    task automatic send_runs_until(input int target);
        while (samples_sent < target) send_random_run();
    endtask

    initial begin
        // reset held, then released once
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        // single-sample sequences: 4x, clipped at both rails and just inside them
        send_sample(t_sample'(127), 1'b1);
        send_sample(t_sample'(-128), 1'b1);
        send_sample(t_sample'(0), 1'b1);
        send_sample(t_sample'(31), 1'b1);
        send_sample(t_sample'(32), 1'b1);
        send_sample(t_sample'(-32), 1'b1);
        send_sample(t_sample'(-33), 1'b1);
        send_sample(t_sample'(1), 1'b1);
        // two-sample sequence: both edges repeated
        send_sample(t_sample'(10), 1'b0);
        send_sample(t_sample'(20), 1'b1);
        // positive and negative saturation in the middle and at the end
        send_sample(t_sample'(100), 1'b0);
        send_sample(t_sample'(100), 1'b0);
        send_sample(t_sample'(100), 1'b1);
        send_sample(t_sample'(-100), 1'b0);
        send_sample(t_sample'(-128), 1'b0);
        send_sample(t_sample'(-128), 1'b1);
        // alternating rails: middle sums nearly cancel out, edge sums clip
        send_sample(t_sample'(127), 1'b0);
        send_sample(t_sample'(-128), 1'b0);
        send_sample(t_sample'(127), 1'b0);
        send_sample(t_sample'(-128), 1'b1);
        // toggling bit patterns
        send_sample(t_sample'(-1), 1'b0);
        send_sample(t_sample'(85), 1'b0);
        send_sample(t_sample'(-86), 1'b1);
        runs_sent += 13;

        // random part, phase one: no idling on either side
        send_runs_until(samples_sent + 60);
        // receiver holds off for a long stretch while samples keep coming,
        // so the result queue fills and the input side stalls
        hold_left = HOLD_CYCLES;
        send_runs_until(samples_sent + 400);

        // sender idles about half the time
        idle_pct  = 53;
        stall_pct = 0;
        send_runs_until(samples_sent + 500);

        // receiver stalls about half the time
        idle_pct  = 0;
        stall_pct = 53;
        send_runs_until(samples_sent + 500);

        // light idling on both sides
        idle_pct  = 7;
        stall_pct = 7;
        send_runs_until(RUN_ITEMS);

        // drain: stop offering, let every expected result come out
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        stall_pct = 0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("covered %0d samples in %0d sequences under four idling mixes",
                 samples_sent, runs_sent);
        $display("checked %0d results, %0d of them clipped to the int8 range",
                 results_checked, clipped_results);
        if (fail_count == 0) begin
            $display("PASS smooth_121_int8_saturating");
        end else begin
            $display("FAIL smooth_121_int8_saturating");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results still expected", pending_results);
        $display("FAIL smooth_121_int8_saturating");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/s121_pkg.sv
hw/rtl/s121_cell.sv
hw/rtl/s121_outq.sv
hw/rtl/smooth_121_int8_saturating.sv
tb/smooth_121_check.sv
tb/tb.sv
